[design/lpi_pkg.sv]
// shared types and constants of the line point interpolator
`timescale 1ns / 1ps
package lpi_pkg;

    localparam int CoordBits = 12;
    localparam int ProdBits  = 2 * CoordBits;

    typedef logic [CoordBits-1:0] coord_t;
    typedef logic [ProdBits-1:0]  prod_t;

    // one input item
    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        coord_t step_index;
    } in_item_t;

    // one result item
    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        logic   in_range;
    } out_item_t;

    // after decode: axis chosen, major coordinate done
    typedef struct packed {
        logic   in_range;
        logic   x_major;
        logic   minor_neg;
        coord_t major_pt;
        coord_t minor_start;
        coord_t mag;
        coord_t idx;
        coord_t len;
    } front_t;

    // division in flight: partial remainder, dividend bits left, quotient so far
    typedef struct packed {
        logic   in_range;
        logic   x_major;
        logic   minor_neg;
        coord_t major_pt;
        coord_t minor_start;
        coord_t len;
        coord_t rem;
        coord_t low;
        coord_t quo;
    } div_t;

endpackage

[design/lpi_req_if.sv]
// request channel: segment endpoints and step index
`timescale 1ns / 1ps
interface lpi_req_if;
    import lpi_pkg::*;

    logic   valid;
    logic   ready;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    coord_t step_index;

    modport source (
        output valid, start_x, start_y, end_x, end_y, step_index,
        input  ready
    );

    modport sink (
        input  valid, start_x, start_y, end_x, end_y, step_index,
        output ready
    );
endinterface

[design/lpi_rsp_if.sv]
// response channel: one pixel and its range flag
`timescale 1ns / 1ps
interface lpi_rsp_if;
    import lpi_pkg::*;

    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_y;
    logic   in_range;

    modport source (
        output valid, point_x, point_y, in_range,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, in_range,
        output ready
    );
endinterface

[design/lpi_front.sv]
// decode stage: axis lengths, major axis, range test, major coordinate
`timescale 1ns / 1ps
module lpi_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  lpi_pkg::in_item_t in_item,
    output logic              out_valid_reg,
    output lpi_pkg::front_t   out_reg
);
    import lpi_pkg::*;

    coord_t lx;
    coord_t ly;
    logic   x_major;
    coord_t maj_s;
    coord_t maj_e;
    coord_t min_s;
    coord_t min_e;
    front_t out_next;

    always_comb
    begin
        lx = (in_item.start_x >= in_item.end_x) ? in_item.start_x - in_item.end_x
                                                : in_item.end_x - in_item.start_x;
        ly = (in_item.start_y >= in_item.end_y) ? in_item.start_y - in_item.end_y
                                                : in_item.end_y - in_item.start_y;
        // tie goes to y
        x_major = lx > ly;
        maj_s = x_major ? in_item.start_x : in_item.start_y;
        maj_e = x_major ? in_item.end_x   : in_item.end_y;
        min_s = x_major ? in_item.start_y : in_item.start_x;
        min_e = x_major ? in_item.end_y   : in_item.end_x;

        out_next.x_major     = x_major;
        out_next.len         = x_major ? lx : ly;
        out_next.mag         = x_major ? ly : lx;
        out_next.idx         = in_item.step_index;
        out_next.in_range    = in_item.step_index < out_next.len;
        out_next.major_pt    = (maj_e >= maj_s) ? maj_s + in_item.step_index
                                                : maj_s - in_item.step_index;
        out_next.minor_start = min_s;
        out_next.minor_neg   = min_e < min_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end
endmodule

[design/lpi_mul.sv]
// product stage: minor magnitude times index, division set up
`timescale 1ns / 1ps
module lpi_mul (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  lpi_pkg::front_t in_reg,
    output logic            out_valid_reg,
    output lpi_pkg::div_t   out_reg
);
    import lpi_pkg::*;

    prod_t prod;
    div_t  out_next;

    always_comb
    begin
        prod = prod_t'(in_reg.mag) * prod_t'(in_reg.idx);
        out_next.in_range    = in_reg.in_range;
        out_next.x_major     = in_reg.x_major;
        out_next.minor_neg   = in_reg.minor_neg;
        out_next.major_pt    = in_reg.major_pt;
        out_next.minor_start = in_reg.minor_start;
        out_next.len         = in_reg.len;
        // upper half is below len whenever the index is in range
        out_next.rem         = prod[ProdBits-1:CoordBits];
        out_next.low         = prod[CoordBits-1:0];
        out_next.quo         = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end
endmodule

[design/lpi_div_step.sv]
// one restoring division step: one quotient bit per stage
`timescale 1ns / 1ps
module lpi_div_step (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  lpi_pkg::div_t in_reg,
    output logic          out_valid_reg,
    output lpi_pkg::div_t out_reg
);
    import lpi_pkg::*;

    logic [CoordBits:0] trial;
    logic [CoordBits:0] diff;
    logic               ge;
    div_t               out_next;

    always_comb
    begin
        trial = {in_reg.rem, in_reg.low[CoordBits-1]};
        diff  = trial - {1'b0, in_reg.len};
        ge    = trial >= {1'b0, in_reg.len};

        out_next     = in_reg;
        out_next.rem = ge ? diff[CoordBits-1:0] : trial[CoordBits-1:0];
        out_next.low = {in_reg.low[CoordBits-2:0], 1'b0};
        out_next.quo = {in_reg.quo[CoordBits-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end
endmodule

[design/lpi_back.sv]
// output stage: floor toward minus infinity, minor coordinate, output register
`timescale 1ns / 1ps
module lpi_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  lpi_pkg::div_t     in_reg,
    output logic              out_valid_reg,
    output lpi_pkg::out_item_t out_reg
);
    import lpi_pkg::*;

    logic               round_up;
    logic [CoordBits:0] q_wide;
    coord_t             minor_pt;
    out_item_t          out_next;

    always_comb
    begin
        // negative delta: ceiling of the magnitude quotient
        round_up = in_reg.minor_neg && (in_reg.rem != '0);
        q_wide   = {1'b0, in_reg.quo} + {{CoordBits{1'b0}}, round_up};
        minor_pt = in_reg.minor_neg ? in_reg.minor_start - q_wide[CoordBits-1:0]
                                    : in_reg.minor_start + q_wide[CoordBits-1:0];

        if (in_reg.in_range)
        begin
            out_next.point_x  = in_reg.x_major ? in_reg.major_pt : minor_pt;
            out_next.point_y  = in_reg.x_major ? minor_pt : in_reg.major_pt;
            out_next.in_range = 1'b1;
        end
        else
        begin
            out_next.point_x  = '0;
            out_next.point_y  = '0;
            out_next.in_range = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end
endmodule

[design/line_point_interpolator_top.sv]
// top level of the line point interpolator
`timescale 1ns / 1ps
// returns pixel step_index of the segment from (start_x, start_y) to
// (end_x, end_y); the axis with the strictly longer length is the major axis
// (a tie picks y), the major coordinate walks from the start toward the end by
// the index, and the minor coordinate is start + floor(delta * index / length);
// an index at or past the major length gives in_range 0 and a zero point.
// one item is taken every cycle while the response side keeps up; the item
// passes decode, multiply, one stage per quotient bit of the restoring
// divider, then the output register. the whole pipe advances together and
// holds when a finished item waits at the output, so req.ready follows the
// response side within the same cycle. no configuration and no state beyond
// the pipe itself.
module line_point_interpolator_top (
    input  logic clk,
    input  logic rst_n,
    lpi_req_if.sink   req,
    lpi_rsp_if.source rsp
);
    import lpi_pkg::*;

    logic      en;
    in_item_t  in_item;

    logic      front_valid;
    front_t    front_q;

    // division pipe: entry 0 from the multiplier, entry CoordBits is done
    logic      div_valid [CoordBits+1];
    div_t      div_q     [CoordBits+1];

    logic      out_valid;
    out_item_t out_q;

    // pipe moves when the output register is empty or being drained
    assign en        = !out_valid || rsp.ready;
    assign req.ready = en;

    assign in_item.start_x    = req.start_x;
    assign in_item.start_y    = req.start_y;
    assign in_item.end_x      = req.end_x;
    assign in_item.end_y      = req.end_y;
    assign in_item.step_index = req.step_index;

    lpi_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (req.valid),
        .in_item       (in_item),
        .out_valid_reg (front_valid),
        .out_reg       (front_q)
    );

    lpi_mul u_mul (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (front_valid),
        .in_reg        (front_q),
        .out_valid_reg (div_valid[0]),
        .out_reg       (div_q[0])
    );

    // one quotient bit per stage, most significant first
    for (genvar i = 0; i < CoordBits; i++)
    begin : g_div
        lpi_div_step u_step (
            .clk           (clk),
            .rst_n         (rst_n),
            .en            (en),
            .in_valid      (div_valid[i]),
            .in_reg        (div_q[i]),
            .out_valid_reg (div_valid[i+1]),
            .out_reg       (div_q[i+1])
        );
    end

    lpi_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (div_valid[CoordBits]),
        .in_reg        (div_q[CoordBits]),
        .out_valid_reg (out_valid),
        .out_reg       (out_q)
    );

    assign rsp.valid    = out_valid;
    assign rsp.point_x  = out_q.point_x;
    assign rsp.point_y  = out_q.point_y;
    assign rsp.in_range = out_q.in_range;
endmodule

[design/lpi_checker.sv]
// port-level checks on the line point interpolator, bound to the top level
`timescale 1ns / 1ps
module lpi_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input lpi_pkg::coord_t point_x,
    input lpi_pkg::coord_t point_y,
    input logic           in_range
);
    import lpi_pkg::*;

    // an index past the end yields the zero point
    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !in_range |-> point_x == '0 && point_y == '0)
        else $error("out of range item with nonzero point");

    // the pipe never blocks the request side while the response side drains
    a_ready_when_draining: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_ready |-> req_ready)
        else $error("request stalled while response side is ready");

    // with nothing at the output the pipe must be free to take an item
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request stalled with an empty output");

    // a waiting result holds its place and value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(point_x)
            && $stable(point_y) && $stable(in_range))
        else $error("stalled result changed or dropped");
endmodule

bind line_point_interpolator_top lpi_checker u_lpi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .point_x   (rsp.point_x),
    .point_y   (rsp.point_y),
    .in_range  (rsp.in_range)
);

[dv/lpi_point_checker.sv]
// checker for the line point interpolator: predicts each pixel and compares results
`timescale 1ns / 1ps
module lpi_point_checker (
    input  logic clk,
    input  logic rst_n,
    lpi_req_if   req,
    lpi_rsp_if   rsp,
    output int   fail_count,
    output int   pending
);
    import lpi_pkg::*;

    out_item_t expected_points[$];

    // pixel step_index of the segment, or a zero point when the index is past the end
    function automatic out_item_t predict_point(input in_item_t seg);
        coord_t             len_x;
        coord_t             len_y;
        coord_t             seg_len;
        coord_t             maj_start;
        coord_t             maj_end;
        coord_t             min_start;
        coord_t             min_end;
        coord_t             min_mag;
        coord_t             maj_pt;
        coord_t             min_pt;
        logic               x_major;
        logic [ProdBits:0]  prod;
        logic [ProdBits:0]  quo;
        logic [ProdBits:0]  len_w;
        out_item_t          pt;

        pt      = '0;
        len_x   = (seg.end_x >= seg.start_x) ? seg.end_x - seg.start_x
                                             : seg.start_x - seg.end_x;
        len_y   = (seg.end_y >= seg.start_y) ? seg.end_y - seg.start_y
                                             : seg.start_y - seg.end_y;
        x_major = len_x > len_y;
        seg_len = x_major ? len_x : len_y;
        if (seg.step_index >= seg_len)
            return pt;

        maj_start = x_major ? seg.start_x : seg.start_y;
        maj_end   = x_major ? seg.end_x   : seg.end_y;
        min_start = x_major ? seg.start_y : seg.start_x;
        min_end   = x_major ? seg.end_y   : seg.end_x;

        maj_pt = (maj_end >= maj_start) ? maj_start + seg.step_index
                                        : maj_start - seg.step_index;

        min_mag = (min_end >= min_start) ? min_end - min_start : min_start - min_end;
        len_w   = {{(ProdBits+1-CoordBits){1'b0}}, seg_len};
        prod    = {{(ProdBits+1-CoordBits){1'b0}}, min_mag}
                * {{(ProdBits+1-CoordBits){1'b0}}, seg.step_index};
        if (min_end >= min_start)
        begin
            quo    = prod / len_w;
            min_pt = min_start + quo[CoordBits-1:0];
        end
        else
        begin
            // floor of a negative quotient is minus the ceiling of its magnitude
            quo    = (prod + len_w - {{ProdBits{1'b0}}, 1'b1}) / len_w;
            min_pt = min_start - quo[CoordBits-1:0];
        end

        pt.point_x  = x_major ? maj_pt : min_pt;
        pt.point_y  = x_major ? min_pt : maj_pt;
        pt.in_range = 1'b1;
        return pt;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        in_item_t  seg;
        if (!rst_n)
        begin
            fail_count = 0;
            pending    = 0;
            expected_points.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_points.size() == 0)
                    report_mismatch("unexpected result item", 1, 0);
                else
                begin
                    want = expected_points.pop_front();
                    if (rsp.point_x !== want.point_x)
                        report_mismatch("point_x", int'(rsp.point_x), int'(want.point_x));
                    if (rsp.point_y !== want.point_y)
                        report_mismatch("point_y", int'(rsp.point_y), int'(want.point_y));
                    if (rsp.in_range !== want.in_range)
                        report_mismatch("in_range", int'(rsp.in_range),
                                        int'(want.in_range));
                end
            end
            if (req.valid && req.ready)
            begin
                seg.start_x    = req.start_x;
                seg.start_y    = req.start_y;
                seg.end_x      = req.end_x;
                seg.end_y      = req.end_y;
                seg.step_index = req.step_index;
                expected_points.push_back(predict_point(seg));
            end
            pending = expected_points.size();
        end
    end

endmodule

[dv/tb_top.sv]
// testbench top of the line point interpolator: stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb_top;
    import lpi_pkg::*;

    localparam int CoordMax   = (1 << CoordBits) - 1;
    localparam int PhaseItems = 388;
    localparam int HoldCycles = 300;
    // settling wait before the verdict, with margin over the pipe depth
    localparam int DrainWait  = 40;
    localparam int CycleLimit = 400000;

    logic clk;
    logic rst_n;

    lpi_req_if req ();
    lpi_rsp_if rsp ();

    int fail_count;
    int pending;
    int cycle_count;

    // flow-control knobs, percent of cycles spent idle or stalled
    int src_idle_pct;
    int snk_stall_pct;

    // long receiver hold-off, started by the stimulus and timed in its own process
    bit hold_start;
    bit hold_off;

    line_point_interpolator_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    lpi_point_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CycleLimit)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // receiver: random stalls per phase, forced low during the hold-off
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                rsp.ready <= 1'b0;
            else
                rsp.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // hold-off toggles on rising edges so the receiver sees it settled at the falling edge
    initial
    begin
        hold_off = 1'b0;
        wait (hold_start);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_off = 1'b0;
    end

    // offer one item, with random idle cycles ahead of it; returns at the
    // falling edge after acceptance with valid still high, so back-to-back
    // items never drop valid within one step
    task automatic send_item(input coord_t sx, input coord_t sy, input coord_t ex,
                             input coord_t ey, input coord_t idx);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid      <= 1'b1;
        req.start_x    <= sx;
        req.start_y    <= sy;
        req.end_x      <= ex;
        req.end_y      <= ey;
        req.step_index <= idx;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
    endtask

    initial
    begin
        int     phase;
        int     n;
        int     kind;
        int     pick;
        int     t;
        int     len_x;
        int     len_y;
        int     seg_len;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        coord_t idx;

        // every input known from time zero
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.start_x    = '0;
        req.start_y    = '0;
        req.end_x      = '0;
        req.end_y      = '0;
        req.step_index = '0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        hold_start     = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed items
        // degenerate segments: nothing is ever in range
        send_item(100, 200, 100, 200, 0);
        send_item(CoordMax, CoordMax, CoordMax, CoordMax, CoordMax);
        // full-width horizontal line: first pixel, last pixel, one past the end
        send_item(0, 0, CoordMax, 0, 0);
        send_item(0, 0, CoordMax, 0, CoordMax - 1);
        send_item(0, 0, CoordMax, 0, CoordMax);
        // x walking down, y walking up, y walking down
        send_item(CoordMax, 7, 0, 7, 1000);
        send_item(0, 0, 0, CoordMax, CoordMax - 1);
        send_item(5, CoordMax, 5, 0, 3000);
        // equal lengths pick y as the major axis
        send_item(0, 0, CoordMax, CoordMax, 2047);
        send_item(CoordMax, 0, 0, CoordMax, CoordMax - 1);
        send_item(0, CoordMax, CoordMax, 0, 1);
        send_item(0, 0, 1, 1, 0);
        // assorted segments, including ones where the floor matters for a negative minor delta
        send_item(10, 10, 13, 11, 1);
        send_item(10, 10, 13, 9, 1);
        send_item(10, 10, 13, 9, 2);
        send_item(0, CoordMax, CoordMax, CoordMax - 1, CoordMax - 1);
        send_item(CoordMax, 0, CoordMax - 1, CoordMax, 2048);
        send_item(CoordMax, CoordMax, 0, 0, 0);
        send_item(2000, 3000, 2003, 10, 2989);
        send_item(CoordMax, CoordMax, 0, CoordMax, CoordMax);
        send_item(0, 0, 1, 0, 0);
        send_item(1234, 2345, 3456, 4000, CoordMax);

        // random phases, each with its own idling pattern
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct  = 65;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 65;
                end
                default:
                begin
                    src_idle_pct  = 11;
                    snk_stall_pct = 11;
                end
            endcase
            for (n = 0; n < PhaseItems; n++)
            begin
                // sender keeps offering during the long receiver stall, so the pipe backs up
                if (phase == 0 && n == 40)
                    hold_start = 1'b1;

                kind = $urandom_range(99);
                sx   = coord_t'($urandom_range(CoordMax));
                sy   = coord_t'($urandom_range(CoordMax));
                if (kind < 45)
                begin
                    // arbitrary segment anywhere on the grid
                    ex = coord_t'($urandom_range(CoordMax));
                    ey = coord_t'($urandom_range(CoordMax));
                end
                else if (kind < 75)
                begin
                    // short segment around the start, clipped to the grid
                    t = int'(sx) + int'($urandom_range(16)) - 8;
                    ex = coord_t'((t < 0) ? 0 : (t > CoordMax) ? CoordMax : t);
                    t = int'(sy) + int'($urandom_range(16)) - 8;
                    ey = coord_t'((t < 0) ? 0 : (t > CoordMax) ? CoordMax : t);
                end
                else if (kind < 83)
                begin
                    ex = sx;
                    ey = sy;
                end
                else if (kind < 91)
                begin
                    // diagonal: both lengths equal, unless y has no room on either side (then y stays put)
                    t  = int'($urandom_range(CoordMax));
                    ex = coord_t'((int'(sx) + t > CoordMax)
                                  ? int'(sx) - (int'(sx) < t ? int'(sx) : t)
                                  : int'(sx) + t);
                    t  = int'((ex >= sx) ? ex - sx : sx - ex);
                    ey = coord_t'((int'(sy) + t > CoordMax) ? int'(sy) - t : int'(sy) + t);
                    if (int'(sy) + t > CoordMax && int'(sy) < t)
                        ey = sy;
                end
                else
                begin
                    // axis-aligned
                    if ($urandom_range(1))
                    begin
                        ex = coord_t'($urandom_range(CoordMax));
                        ey = sy;
                    end
                    else
                    begin
                        ex = sx;
                        ey = coord_t'($urandom_range(CoordMax));
                    end
                end

                len_x   = int'((ex >= sx) ? ex - sx : sx - ex);
                len_y   = int'((ey >= sy) ? ey - sy : sy - ey);
                seg_len = (len_x > len_y) ? len_x : len_y;
                pick    = $urandom_range(99);
                if (seg_len == 0 || pick < 10)
                    idx = coord_t'($urandom_range(CoordMax));
                else if (pick < 18)
                    idx = coord_t'(seg_len);
                else
                    idx = coord_t'($urandom_range(seg_len - 1));

                send_item(sx, sy, ex, ey, idx);
            end

            // sender pauses until every result of the phase is back
            req.valid <= 1'b0;
            while (pending != 0)
                @(negedge clk);
        end

        // let any stray result show up before the verdict
        repeat (DrainWait) @(negedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
